@@ design/vertex_rotate_project_defines.svh @@
`ifndef VERTEX_ROTATE_PROJECT_DEFINES_SVH
`define VERTEX_ROTATE_PROJECT_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define VRP_ASSERT_IMP(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("%m: label failed");
// Next-cycle implication checked outside reset.
`define VRP_ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("%m: label failed");
`endif

@@ design/vrp_pkg.sv @@
package vrp_pkg;
    localparam int CoordW   = 8;
    localparam int AngleW   = 8;
    localparam int PdW      = 10;
    localparam int CenterW  = 9;
    localparam int ScreenW  = 19;
    localparam int FracBits = 12;
    localparam int TrigW    = 14;   // -4096..4096
    localparam int RotW     = 10;   // rotated coordinates stay within +-222
    localparam int NumW     = 21;   // rot * pd, signed
    localparam int DenW     = 12;   // depth, 1..2268
    localparam int QuotW    = NumW;
    localparam int DivStageBits = 4;    // divider quotient bits per stage

    localparam logic [1:0] RegPd     = 2'd0;
    localparam logic [1:0] RegOffset = 2'd1;
    localparam logic [1:0] RegCx     = 2'd2;
    localparam logic [1:0] RegCy     = 2'd3;
    localparam int CfgIdxW = 8;

    localparam logic [PdW-1:0]     PdReset     = 10'd200;
    localparam logic [PdW-1:0]     OffsetReset = 10'd80;
    localparam logic [CenterW-1:0] CxReset     = 9'd160;
    localparam logic [CenterW-1:0] CyReset     = 9'd100;

    function automatic logic [12:0] quarter_sine(input logic [6:0] p);
        logic [12:0] r;
        unique case (p)
            7'd0: r = 13'd0;     7'd1: r = 13'd101;   7'd2: r = 13'd201;
            7'd3: r = 13'd301;   7'd4: r = 13'd401;   7'd5: r = 13'd501;
            7'd6: r = 13'd601;   7'd7: r = 13'd700;   7'd8: r = 13'd799;
            7'd9: r = 13'd897;   7'd10: r = 13'd995;  7'd11: r = 13'd1092;
            7'd12: r = 13'd1189; 7'd13: r = 13'd1285; 7'd14: r = 13'd1380;
            7'd15: r = 13'd1474; 7'd16: r = 13'd1567; 7'd17: r = 13'd1660;
            7'd18: r = 13'd1751; 7'd19: r = 13'd1842; 7'd20: r = 13'd1931;
            7'd21: r = 13'd2019; 7'd22: r = 13'd2106; 7'd23: r = 13'd2191;
            7'd24: r = 13'd2276; 7'd25: r = 13'd2359; 7'd26: r = 13'd2440;
            7'd27: r = 13'd2520; 7'd28: r = 13'd2598; 7'd29: r = 13'd2675;
            7'd30: r = 13'd2751; 7'd31: r = 13'd2824; 7'd32: r = 13'd2896;
            7'd33: r = 13'd2967; 7'd34: r = 13'd3035; 7'd35: r = 13'd3102;
            7'd36: r = 13'd3166; 7'd37: r = 13'd3229; 7'd38: r = 13'd3290;
            7'd39: r = 13'd3349; 7'd40: r = 13'd3406; 7'd41: r = 13'd3461;
            7'd42: r = 13'd3513; 7'd43: r = 13'd3564; 7'd44: r = 13'd3612;
            7'd45: r = 13'd3659; 7'd46: r = 13'd3703; 7'd47: r = 13'd3745;
            7'd48: r = 13'd3784; 7'd49: r = 13'd3822; 7'd50: r = 13'd3857;
            7'd51: r = 13'd3889; 7'd52: r = 13'd3920; 7'd53: r = 13'd3948;
            7'd54: r = 13'd3973; 7'd55: r = 13'd3996; 7'd56: r = 13'd4017;
            7'd57: r = 13'd4036; 7'd58: r = 13'd4052; 7'd59: r = 13'd4065;
            7'd60: r = 13'd4076; 7'd61: r = 13'd4085; 7'd62: r = 13'd4091;
            7'd63: r = 13'd4095; 7'd64: r = 13'd4096;
            default: r = 13'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [TrigW-1:0] sine_of(input logic [AngleW-1:0] a);
        logic [6:0]  pos;
        logic [12:0] mag;
        pos = {1'b0, a[5:0]};
        mag = a[6] ? quarter_sine(7'd64 - pos) : quarter_sine(pos);
        return a[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction
endpackage

@@ design/vrp_rotate.sv @@
// Two rotations, four register stages; one item per cycle when not stalled.
module vrp_rotate (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic signed [vrp_pkg::CoordW-1:0]  x_in,
    input  logic signed [vrp_pkg::CoordW-1:0]  y_in,
    input  logic signed [vrp_pkg::CoordW-1:0]  z_in,
    input  logic        [vrp_pkg::AngleW-1:0]  ax_in,
    input  logic        [vrp_pkg::AngleW-1:0]  ay_in,
    output logic                               out_valid,
    output logic signed [vrp_pkg::RotW-1:0]    x1_out,
    output logic signed [vrp_pkg::RotW-1:0]    y2_out,
    output logic signed [vrp_pkg::RotW-1:0]    z2_out
);
    import vrp_pkg::*;
    localparam int PW = 24;

    // stage 1: sine/cosine lookup
    logic [3:0] v_reg;
    logic signed [CoordW-1:0] x_s1_reg, y_s1_reg, z_s1_reg;
    logic signed [TrigW-1:0]  sy_reg, cy_reg, sx_reg, cx_reg;
    // stage 2: first rotation products
    logic signed [PW-1:0] p_cz_reg, p_sx_reg, p_cx_reg, p_sz_reg;
    logic signed [CoordW-1:0] y_s2_reg;
    logic signed [TrigW-1:0]  sx2_reg, cx2_reg;
    // stage 3: x1, z1
    logic signed [RotW-1:0] x1_s3_reg, z1_reg;
    logic signed [CoordW-1:0] y_s3_reg;
    logic signed [TrigW-1:0]  sx3_reg, cx3_reg;
    // stage 4: second rotation products
    logic signed [PW-1:0] q_cy_reg, q_sz_reg, q_sy_reg, q_cz_reg;
    logic signed [RotW-1:0] x1_s4_reg;
    logic signed [PW-1:0] s1x, s1z, s2y, s2z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    assign s1x = p_cx_reg + p_sz_reg;
    assign s1z = p_cz_reg - p_sx_reg;
    assign s2y = q_cy_reg - q_sz_reg;
    assign s2z = q_sy_reg + q_cz_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            x_s1_reg <= x_in; y_s1_reg <= y_in; z_s1_reg <= z_in;
            sy_reg <= sine_of(ay_in);
            cy_reg <= sine_of(ay_in + AngleW'(64));
            sx_reg <= sine_of(ax_in);
            cx_reg <= sine_of(ax_in + AngleW'(64));

            p_cx_reg <= PW'(cy_reg * x_s1_reg);
            p_sz_reg <= PW'(sy_reg * z_s1_reg);
            p_cz_reg <= PW'(cy_reg * z_s1_reg);
            p_sx_reg <= PW'(sy_reg * x_s1_reg);
            y_s2_reg <= y_s1_reg; sx2_reg <= sx_reg; cx2_reg <= cx_reg;

            x1_s3_reg <= RotW'(s1x >>> FracBits);
            z1_reg    <= RotW'(s1z >>> FracBits);
            y_s3_reg <= y_s2_reg; sx3_reg <= sx2_reg; cx3_reg <= cx2_reg;

            q_cy_reg <= PW'(cx3_reg * y_s3_reg);
            q_sz_reg <= PW'(sx3_reg * z1_reg);
            q_sy_reg <= PW'(sx3_reg * y_s3_reg);
            q_cz_reg <= PW'(cx3_reg * z1_reg);
            x1_s4_reg <= x1_s3_reg;
        end
    end

    assign out_valid = v_reg[3];
    assign x1_out = x1_s4_reg;
    assign y2_out = RotW'(s2y >>> FracBits);
    assign z2_out = RotW'(s2z >>> FracBits);
endmodule

@@ design/vrp_divide.sv @@
// Pipelined restoring divider, BitsPerStage quotient bits per stage.
// Magnitudes divided, sign restored at the end (truncation toward zero).
module vrp_divide #(
    parameter int BitsPerStage = vrp_pkg::DivStageBits
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic signed [vrp_pkg::NumW-1:0]    num_x,
    input  logic signed [vrp_pkg::NumW-1:0]    num_y,
    input  logic        [vrp_pkg::DenW-1:0]    den,
    input  logic        [vrp_pkg::CenterW-1:0] cx_in,
    input  logic        [vrp_pkg::CenterW-1:0] cy_in,
    output logic                               out_valid,
    output logic        [vrp_pkg::ScreenW-1:0] sx_out,
    output logic        [vrp_pkg::ScreenW-1:0] sy_out
);
    import vrp_pkg::*;
    localparam int MW = NumW;   // magnitude width (one spare bit)
    localparam int NS = (MW + BitsPerStage - 1) / BitsPerStage;
    localparam int TW = NS * BitsPerStage;
    localparam int RW = DenW + 1;

    logic [NS:0]          v_reg;
    logic [TW-1:0]        qx_reg [NS+1];
    logic [TW-1:0]        qy_reg [NS+1];
    logic [RW-1:0]        rx_reg [NS+1];
    logic [RW-1:0]        ry_reg [NS+1];
    logic [DenW-1:0]      d_reg  [NS+1];
    logic                 nx_reg [NS+1];
    logic                 ny_reg [NS+1];
    logic [CenterW-1:0]   cx_reg [NS+1];
    logic [CenterW-1:0]   cy_reg [NS+1];
    logic [MW-1:0]        ax, ay;
    logic signed [ScreenW-1:0] fx, fy;

    assign ax = num_x[NumW-1] ? MW'(-num_x) : MW'(num_x);
    assign ay = num_y[NumW-1] ? MW'(-num_y) : MW'(num_y);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NS-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qx_reg[0] <= TW'(ax); qy_reg[0] <= TW'(ay);
            rx_reg[0] <= '0; ry_reg[0] <= '0;
            d_reg[0] <= den;
            nx_reg[0] <= num_x[NumW-1]; ny_reg[0] <= num_y[NumW-1];
            cx_reg[0] <= cx_in; cy_reg[0] <= cy_in;
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [TW-1:0] qx, qy;
        logic [RW-1:0] rx, ry;
        always_comb begin
            qx = qx_reg[s]; qy = qy_reg[s];
            rx = rx_reg[s]; ry = ry_reg[s];
            for (int b = 0; b < BitsPerStage; b++) begin
                rx = {rx[RW-2:0], qx[TW-1]};
                qx = {qx[TW-2:0], 1'b0};
                if (rx >= {1'b0, d_reg[s]}) begin
                    rx = rx - {1'b0, d_reg[s]};
                    qx[0] = 1'b1;
                end
                ry = {ry[RW-2:0], qy[TW-1]};
                qy = {qy[TW-2:0], 1'b0};
                if (ry >= {1'b0, d_reg[s]}) begin
                    ry = ry - {1'b0, d_reg[s]};
                    qy[0] = 1'b1;
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                qx_reg[s+1] <= qx; qy_reg[s+1] <= qy;
                rx_reg[s+1] <= rx; ry_reg[s+1] <= ry;
                d_reg[s+1] <= d_reg[s];
                nx_reg[s+1] <= nx_reg[s]; ny_reg[s+1] <= ny_reg[s];
                cx_reg[s+1] <= cx_reg[s]; cy_reg[s+1] <= cy_reg[s];
            end
        end
    end

    assign fx = nx_reg[NS] ? -ScreenW'(qx_reg[NS]) : ScreenW'(qx_reg[NS]);
    assign fy = ny_reg[NS] ? -ScreenW'(qy_reg[NS]) : ScreenW'(qy_reg[NS]);
    assign sx_out = ScreenW'(fx + $signed({1'b0, cx_reg[NS]}));
    assign sy_out = ScreenW'(fy + $signed({1'b0, cy_reg[NS]}));
    assign out_valid = v_reg[NS];
endmodule

@@ design/vertex_rotate_project.sv @@
// Pipeline: 4 rotation stages + 1 projection stage + ceil(21/DivBits)+1 divider
// stages + 1 output register.
// Throughput: one item per cycle; the pipeline advances whenever the output
// register is empty or being taken.
// Reset (aresetn low, synchronous): pipeline emptied, registers return to
// pd 200, offset 80, center (160,100).
module vertex_rotate_project #(
    parameter int DivBits = vrp_pkg::DivStageBits
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [vrp_pkg::CoordW-1:0]  s_vertex_x,
    input  logic signed [vrp_pkg::CoordW-1:0]  s_vertex_y,
    input  logic signed [vrp_pkg::CoordW-1:0]  s_vertex_z,
    input  logic        [vrp_pkg::AngleW-1:0]  s_angle_about_x,
    input  logic        [vrp_pkg::AngleW-1:0]  s_angle_about_y,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [vrp_pkg::ScreenW-1:0] m_screen_x,
    output logic signed [vrp_pkg::ScreenW-1:0] m_screen_y,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic        [vrp_pkg::CfgIdxW-1:0] cfg_index,
    input  logic        [31:0]                 cfg_data
);
    import vrp_pkg::*;

    logic [PdW-1:0]     pd_reg, off_reg;
    logic [CenterW-1:0] cx_reg, cy_reg;
    logic en;
    logic rot_v;
    logic signed [RotW-1:0] x1, y2, z2;
    logic p_v_reg;
    logic signed [NumW-1:0] nx_reg, ny_reg;
    logic [DenW-1:0] den_reg;
    logic signed [DenW+1:0] zsum;
    logic div_v;
    logic [ScreenW-1:0] dx, dy;
    logic m_valid_reg;
    logic [ScreenW-1:0] sx_reg, sy_reg;

    // whole pipeline advances together; output register holds while stalled
    assign en = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pd_reg <= PdReset; off_reg <= OffsetReset;
            cx_reg <= CxReset; cy_reg <= CyReset;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CfgIdxW'(RegPd):     pd_reg  <= cfg_data[PdW-1:0];
                CfgIdxW'(RegOffset): off_reg <= cfg_data[PdW-1:0];
                CfgIdxW'(RegCx):     cx_reg  <= cfg_data[CenterW-1:0];
                CfgIdxW'(RegCy):     cy_reg  <= cfg_data[CenterW-1:0];
                default: ;
            endcase
        end
    end

    vrp_rotate u_rot (
        .aclk, .aresetn, .en,
        .in_valid (s_valid),
        .x_in (s_vertex_x), .y_in (s_vertex_y), .z_in (s_vertex_z),
        .ax_in (s_angle_about_x), .ay_in (s_angle_about_y),
        .out_valid (rot_v), .x1_out (x1), .y2_out (y2), .z2_out (z2)
    );

    assign zsum = (DenW+2)'(z2) + $signed({4'b0, pd_reg}) + $signed({4'b0, off_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_v_reg <= 1'b0;
        end else if (en) begin
            p_v_reg <= rot_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nx_reg <= NumW'(x1 * $signed({1'b0, pd_reg}));
            ny_reg <= NumW'(y2 * $signed({1'b0, pd_reg}));
            den_reg <= (zsum < (DenW+2)'(1)) ? DenW'(1) : DenW'(zsum);
        end
    end

    vrp_divide #(.BitsPerStage (DivBits)) u_div (
        .aclk, .aresetn, .en,
        .in_valid (p_v_reg),
        .num_x (nx_reg), .num_y (ny_reg), .den (den_reg),
        .cx_in (cx_reg), .cy_in (cy_reg),
        .out_valid (div_v), .sx_out (dx), .sy_out (dy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= div_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sx_reg <= dx; sy_reg <= dy;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_screen_x = sx_reg;
    assign m_screen_y = sy_reg;
endmodule

@@ design/vrp_checker.sv @@
`include "vertex_rotate_project_defines.svh"
module vrp_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic cfg_ready,
    input logic [18:0] m_screen_x
);
    `VRP_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `VRP_ASSERT_NEXT(a_m_data, aclk, aresetn, m_valid && !m_ready, $stable(m_screen_x))
    `VRP_ASSERT_IMP(a_ready_idle, aclk, aresetn, !m_valid, s_ready)
    `VRP_ASSERT_IMP(a_cfg_rdy, aclk, aresetn, 1'b1, cfg_ready)
endmodule

bind vertex_rotate_project vrp_checker u_chk (
    .aclk, .aresetn, .s_ready, .m_valid, .m_ready, .cfg_ready, .m_screen_x
);
